// ----- design/tcw_pkg.sv -----
package tcw_pkg;

	localparam int DEF_ROWS = 25;
	localparam int DEF_COLS = 80;

	localparam int CELL_W = 16;
	localparam int CHAR_W = 8;
	localparam int FUNC_W = 3;
	localparam int IN_ROW_W = 5;
	localparam int IN_COL_W = 7;
	localparam int POS_W = 11;

	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 32;

	localparam logic [CHAR_W-1:0] RESET_COLOUR = 8'h0F;
	localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
	localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
	localparam logic [CHAR_W-1:0] TAB_CHAR = 8'h09;

	localparam logic [FUNC_W-1:0] FN_PUT_CHAR = 3'd0;
	localparam logic [FUNC_W-1:0] FN_SET_POS = 3'd1;
	localparam logic [FUNC_W-1:0] FN_CLEAR = 3'd2;
	localparam logic [FUNC_W-1:0] FN_SAVE_POS = 3'd3;
	localparam logic [FUNC_W-1:0] FN_RESTORE_POS = 3'd4;
	localparam logic [FUNC_W-1:0] FN_READ_CELL = 3'd5;

	typedef logic [CELL_W-1:0] cell_t;

endpackage

// ----- design/text_console_writer.sv -----
// text console writer: ROWS x COLS screen of 16-bit cells in one single-port ram
// result registered in state FIN, then in the output register (read cell passes
// through state READ first for the ram read); no new item is accepted until the
// result is registered. clear sweeps the ram, one write per cell, as does a put
// char that runs off the last row. reset: cursor, saved position and colour reset
// at once, then the ram is swept with blank cells while no item is accepted
module text_console_writer #(
	parameter int ROWS = tcw_pkg::DEF_ROWS,
	parameter int COLS = tcw_pkg::DEF_COLS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// char_code [7:0], row [12:8], col [19:13]
	input  logic [tcw_pkg::S_TDATA_W-1:0]  s_tdata,
	// func [2:0]
	input  logic [tcw_pkg::FUNC_W-1:0]     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// cursor_position [10:0], cell_data [26:11]
	output logic [tcw_pkg::M_TDATA_W-1:0]  m_tdata,
	input  logic                           cfg_we,
	input  logic [tcw_pkg::CHAR_W-1:0]     cfg_wdata
);
	import tcw_pkg::*;

	localparam int CELLS = ROWS * COLS;
	localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int CW = $clog2(COLS);

	localparam logic [2:0] ST_INIT = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_READ = 3'd2;
	localparam logic [2:0] ST_SWEEP = 3'd3;
	localparam logic [2:0] ST_FIN = 3'd4;

	logic [2:0] state_q;
	logic [RW-1:0] cur_row_q, saved_row_q, nxt_row;
	logic [CW-1:0] cur_col_q, saved_col_q, nxt_col;
	logic [CHAR_W-1:0] colour_q, sweep_colour_q;
	logic [AW-1:0] sweep_idx_q;
	cell_t res_cell_q;
	logic m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	logic [FUNC_W-1:0] in_func;
	logic [CHAR_W-1:0] in_char;
	logic [IN_ROW_W-1:0] in_row;
	logic [IN_COL_W-1:0] in_col;
	logic [RW-1:0] clamp_row;
	logic [CW-1:0] clamp_col;

	logic accept, sweeping, out_free;
	logic nxt_sweep, nxt_read;
	logic ram_we;
	logic [AW-1:0] ram_addr;
	cell_t ram_wdata, ram_rdata;

	logic [RW:0] row_inc;
	logic [CW:0] col_inc1, col_inc2;

	function automatic logic [AW-1:0] cell_index(input logic [RW-1:0] r, input logic [CW-1:0] c);
		cell_index = AW'(AW'(r) * AW'(COLS)) + AW'(c);
	endfunction

	assign in_func = s_tuser;
	assign in_char = s_tdata[7:0];
	assign in_row = s_tdata[12:8];
	assign in_col = s_tdata[19:13];

	assign clamp_row = (7'(in_row) > 7'(ROWS - 1)) ? RW'(ROWS - 1) : RW'(in_row);
	assign clamp_col = (in_col > 7'(COLS - 1)) ? CW'(COLS - 1) : CW'(in_col);

	assign s_tready = (state_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;
	assign sweeping = (state_q == ST_INIT) || (state_q == ST_SWEEP);
	assign out_free = !m_tvalid_q || m_tready;

	assign row_inc = {1'b0, cur_row_q} + (RW+1)'(1);
	assign col_inc1 = {1'b0, cur_col_q} + (CW+1)'(1);
	assign col_inc2 = {1'b0, cur_col_q} + (CW+1)'(2);

	// next cursor and ram access for the item being accepted, or the sweep write
	always_comb begin
		nxt_row = cur_row_q;
		nxt_col = cur_col_q;
		nxt_sweep = 1'b0;
		nxt_read = 1'b0;
		ram_we = 1'b0;
		ram_addr = cell_index(cur_row_q, cur_col_q);
		ram_wdata = {colour_q, in_char};
		if (sweeping) begin
			ram_we = 1'b1;
			ram_addr = sweep_idx_q;
			ram_wdata = {sweep_colour_q, BLANK_CHAR};
		end else if (accept) begin
			case (in_func)
				FN_PUT_CHAR: begin
					if (in_char == NEWLINE_CHAR) begin
						nxt_col = '0;
						nxt_row = row_inc[RW-1:0];
						if (row_inc >= (RW+1)'(ROWS)) begin
							nxt_row = '0;
							nxt_sweep = 1'b1;
						end
					end else if (in_char == TAB_CHAR) begin
						nxt_col = col_inc2[CW-1:0];
						if (col_inc2 >= (CW+1)'(COLS)) begin
							nxt_col = '0;
							nxt_row = row_inc[RW-1:0];
							if (row_inc >= (RW+1)'(ROWS)) begin
								nxt_row = '0;
								nxt_sweep = 1'b1;
							end
						end
					end else begin
						ram_we = 1'b1;
						nxt_col = col_inc1[CW-1:0];
						if (col_inc1 >= (CW+1)'(COLS)) begin
							nxt_col = '0;
							nxt_row = row_inc[RW-1:0];
							if (row_inc >= (RW+1)'(ROWS)) begin
								nxt_row = '0;
								nxt_sweep = 1'b1;
							end
						end
					end
				end
				FN_SET_POS: begin
					nxt_row = clamp_row;
					nxt_col = clamp_col;
				end
				FN_CLEAR: begin
					nxt_row = '0;
					nxt_col = '0;
					nxt_sweep = 1'b1;
				end
				FN_RESTORE_POS: begin
					nxt_row = saved_row_q;
					nxt_col = saved_col_q;
				end
				FN_READ_CELL: begin
					nxt_read = 1'b1;
					ram_addr = cell_index(clamp_row, clamp_col);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			cur_row_q <= '0;
			cur_col_q <= '0;
			saved_row_q <= '0;
			saved_col_q <= '0;
			colour_q <= RESET_COLOUR;
			sweep_colour_q <= RESET_COLOUR;
			sweep_idx_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				colour_q <= cfg_wdata;
			end
			if (state_q == ST_FIN && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_INIT, ST_SWEEP: begin
					sweep_idx_q <= sweep_idx_q + AW'(1);
					if (sweep_idx_q == AW'(CELLS - 1)) begin
						sweep_idx_q <= '0;
						state_q <= (state_q == ST_INIT) ? ST_IDLE : ST_FIN;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						cur_row_q <= nxt_row;
						cur_col_q <= nxt_col;
						if (in_func == FN_SAVE_POS) begin
							saved_row_q <= cur_row_q;
							saved_col_q <= cur_col_q;
						end
						sweep_colour_q <= colour_q;
						if (nxt_sweep) begin
							state_q <= ST_SWEEP;
						end else if (nxt_read) begin
							state_q <= ST_READ;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			res_cell_q <= '0;
		end else if (state_q == ST_READ) begin
			res_cell_q <= ram_rdata;
		end
		if (state_q == ST_FIN && out_free) begin
			m_tdata_q <= M_TDATA_W'({res_cell_q, POS_W'(cell_index(cur_row_q, cur_col_q))});
		end
	end

	tcw_screen_ram #(
		.DEPTH(CELLS),
		.AW(AW)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.addr(ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

endmodule

// ----- design/tcw_screen_ram.sv -----
module tcw_screen_ram #(
	parameter int DEPTH = tcw_pkg::DEF_ROWS * tcw_pkg::DEF_COLS,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  tcw_pkg::cell_t wdata,
	output tcw_pkg::cell_t rdata
);
	import tcw_pkg::*;

	cell_t mem [DEPTH];
	cell_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

// ----- dv/text_console_writer_tb.sv -----
`timescale 1ns / 1ps

module text_console_writer_tb;
	import tcw_pkg::*;

	localparam int ROWS = DEF_ROWS;
	localparam int COLS = DEF_COLS;
	localparam int CELLS = ROWS * COLS;
	localparam int CELL_AW = $clog2(CELLS);
	localparam int CYCLE_LIMIT = 5_000_000;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int PHASE_ITEMS = 95;
	localparam int NUM_DIRECTED = 27;
	localparam int NUM_PHASES = 5;

	// codes the block leaves unused
	localparam logic [FUNC_W-1:0] FN_SPARE_6 = 3'd6;
	localparam logic [FUNC_W-1:0] FN_SPARE_7 = 3'd7;

	typedef struct packed {
		logic [POS_W-1:0] pos;
		cell_t cell_data;
	} console_report_t;

	typedef struct {
		logic [FUNC_W-1:0] fn;
		logic [CHAR_W-1:0] ch;
		logic [IN_ROW_W-1:0] r;
		logic [IN_COL_W-1:0] c;
		bit fixed;
		logic [POS_W-1:0] pos;
		cell_t cell_data;
	} directed_op_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [FUNC_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [CHAR_W-1:0] cfg_wdata = '0;

	// screen and cursor as the block should hold them
	cell_t screen_model [CELLS];
	logic [IN_ROW_W-1:0] cur_row;
	logic [IN_COL_W-1:0] cur_col;
	logic [IN_ROW_W-1:0] mark_row;
	logic [IN_COL_W-1:0] mark_col;
	logic [CHAR_W-1:0] colour_reg;

	console_report_t expected_reports [$];
	int mismatch_count = 0;
	int cycle_count = 0;
	bit hold_off_req = 1'b0;
	bit no_gaps = 1'b0;

	directed_op_t directed_ops [NUM_DIRECTED] = '{
		'{FN_READ_CELL,   8'h00,        5'd0,  7'd0,   1'b1, 11'd0,    16'h0F20},
		'{FN_READ_CELL,   8'h00,        5'd31, 7'd127, 1'b1, 11'd0,    16'h0F20},
		'{FN_PUT_CHAR,    8'h41,        5'd0,  7'd0,   1'b1, 11'd1,    16'h0000},
		'{FN_PUT_CHAR,    8'hFF,        5'd31, 7'd127, 1'b1, 11'd2,    16'h0000},
		'{FN_PUT_CHAR,    8'h00,        5'd0,  7'd0,   1'b1, 11'd3,    16'h0000},
		'{FN_PUT_CHAR,    TAB_CHAR,     5'd0,  7'd0,   1'b1, 11'd5,    16'h0000},
		'{FN_PUT_CHAR,    NEWLINE_CHAR, 5'd0,  7'd0,   1'b1, 11'd80,   16'h0000},
		'{FN_READ_CELL,   8'h00,        5'd0,  7'd0,   1'b0, 11'd0,    16'h0000},
		'{FN_SET_POS,     8'h00,        5'd24, 7'd78,  1'b1, 11'd1998, 16'h0000},
		'{FN_PUT_CHAR,    8'h5A,        5'd0,  7'd0,   1'b1, 11'd1999, 16'h0000},
		'{FN_SAVE_POS,    8'h00,        5'd0,  7'd0,   1'b1, 11'd1999, 16'h0000},
		'{FN_PUT_CHAR,    8'h51,        5'd0,  7'd0,   1'b1, 11'd0,    16'h0000},
		'{FN_READ_CELL,   8'h00,        5'd24, 7'd78,  1'b1, 11'd0,    16'h0F20},
		'{FN_RESTORE_POS, 8'h00,        5'd0,  7'd0,   1'b1, 11'd1999, 16'h0000},
		'{FN_PUT_CHAR,    TAB_CHAR,     5'd0,  7'd0,   1'b1, 11'd0,    16'h0000},
		'{FN_SET_POS,     8'h00,        5'd31, 7'd127, 1'b1, 11'd1999, 16'h0000},
		'{FN_PUT_CHAR,    NEWLINE_CHAR, 5'd0,  7'd0,   1'b1, 11'd0,    16'h0000},
		'{FN_SET_POS,     8'h00,        5'd5,  7'd78,  1'b1, 11'd478,  16'h0000},
		'{FN_PUT_CHAR,    TAB_CHAR,     5'd0,  7'd0,   1'b1, 11'd480,  16'h0000},
		'{FN_PUT_CHAR,    8'h42,        5'd0,  7'd0,   1'b0, 11'd0,    16'h0000},
		'{FN_READ_CELL,   8'h00,        5'd6,  7'd0,   1'b0, 11'd0,    16'h0000},
		'{FN_SPARE_6,     8'hFF,        5'd31, 7'd127, 1'b0, 11'd0,    16'h0000},
		'{FN_SPARE_7,     8'h00,        5'd0,  7'd0,   1'b0, 11'd0,    16'h0000},
		'{FN_SET_POS,     8'h00,        5'd16, 7'd64,  1'b1, 11'd1344, 16'h0000},
		'{FN_CLEAR,       8'h00,        5'd0,  7'd0,   1'b1, 11'd0,    16'h0000},
		'{FN_READ_CELL,   8'h00,        5'd16, 7'd64,  1'b1, 11'd0,    16'h0F20},
		'{FN_RESTORE_POS, 8'h00,        5'd0,  7'd0,   1'b1, 11'd1999, 16'h0000}
	};

	text_console_writer dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic int idle_span();
		return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
	endfunction

	task automatic blank_screen();
		for (int i = 0; i < CELLS; i++)
			screen_model[CELL_AW'(i)] = {colour_reg, BLANK_CHAR};
		cur_row = '0;
		cur_col = '0;
	endtask

	task automatic next_row();
		cur_col = '0;
		cur_row = cur_row + 5'd1;
		if (cur_row >= ROWS)
			blank_screen();
	endtask

	task automatic model_console_op(input logic [FUNC_W-1:0] fn, input logic [CHAR_W-1:0] ch,
			input logic [IN_ROW_W-1:0] r, input logic [IN_COL_W-1:0] c,
			output console_report_t rep);
		logic [IN_ROW_W-1:0] rr;
		logic [IN_COL_W-1:0] cc;
		rr = (r > ROWS - 1) ? IN_ROW_W'(ROWS - 1) : r;
		cc = (c > COLS - 1) ? IN_COL_W'(COLS - 1) : c;
		rep.cell_data = '0;
		case (fn)
			FN_PUT_CHAR: begin
				if (ch == NEWLINE_CHAR) begin
					next_row();
				end else if (ch == TAB_CHAR) begin
					cur_col = cur_col + 7'd2;
					if (cur_col >= COLS)
						next_row();
				end else begin
					screen_model[CELL_AW'(cur_row * COLS + cur_col)] = {colour_reg, ch};
					cur_col = cur_col + 7'd1;
					if (cur_col >= COLS)
						next_row();
				end
			end
			FN_SET_POS: begin
				cur_row = rr;
				cur_col = cc;
			end
			FN_CLEAR: blank_screen();
			FN_SAVE_POS: begin
				mark_row = cur_row;
				mark_col = cur_col;
			end
			FN_RESTORE_POS: begin
				cur_row = mark_row;
				cur_col = mark_col;
			end
			FN_READ_CELL: rep.cell_data = screen_model[CELL_AW'(rr * COLS + cc)];
			default: ;
		endcase
		rep.pos = POS_W'(cur_row * COLS + cur_col);
	endtask

	task automatic offer_item(input logic [FUNC_W-1:0] fn, input logic [CHAR_W-1:0] ch,
			input logic [IN_ROW_W-1:0] r, input logic [IN_COL_W-1:0] c,
			input bit fixed, input console_report_t fixed_rep);
		int gap;
		console_report_t rep;
		gap = (no_gaps || $urandom_range(0, 1) == 0) ? 0 : idle_span();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= fn;
		s_tdata <= {{(S_TDATA_W - CHAR_W - IN_ROW_W - IN_COL_W){1'b0}}, c, r, ch};
		do @(posedge clk); while (!s_tready);
		model_console_op(fn, ch, r, c, rep);
		expected_reports.push_back(fixed ? fixed_rep : rep);
	endtask

	task automatic random_console_op();
		int pick;
		logic [FUNC_W-1:0] fn;
		logic [CHAR_W-1:0] ch;
		logic [IN_ROW_W-1:0] r;
		logic [IN_COL_W-1:0] c;
		pick = $urandom_range(0, 99);
		ch = CHAR_W'($urandom_range(0, 255));
		r = IN_ROW_W'($urandom_range(0, 31));
		c = IN_COL_W'($urandom_range(0, 127));
		if (pick < 55) begin
			fn = FN_PUT_CHAR;
			if (pick < 5)
				ch = NEWLINE_CHAR;
			else if (pick < 9)
				ch = TAB_CHAR;
		end else if (pick < 67) begin
			fn = FN_SET_POS;
		end else if (pick < 69) begin
			fn = FN_CLEAR;
		end else if (pick < 75) begin
			fn = FN_SAVE_POS;
		end else if (pick < 81) begin
			fn = FN_RESTORE_POS;
		end else if (pick < 97) begin
			fn = FN_READ_CELL;
			// aim at cells written on the current line
			if (pick < 89) begin
				r = cur_row;
				c = IN_COL_W'($urandom_range(0, cur_col));
			end
		end else begin
			fn = (pick % 2 == 0) ? FN_SPARE_6 : FN_SPARE_7;
		end
		offer_item(fn, ch, r, c, 1'b0, '0);
	endtask

	task automatic settle_console(input int extra);
		s_tvalid <= 1'b0;
		while (expected_reports.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic load_colour(input logic [CHAR_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		colour_reg = value;
	endtask

	initial begin : rx_pacing
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else if (!no_gaps && $urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				repeat (idle_span()) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		console_report_t want;
		console_report_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.pos = m_tdata[POS_W-1:0];
			got.cell_data = m_tdata[POS_W +: CELL_W];
			if (expected_reports.size() == 0) begin
				$error("unexpected item: cursor_position %0d cell_data %h", got.pos,
					got.cell_data);
				mismatch_count++;
			end else begin
				want = expected_reports.pop_front();
				if (got.pos !== want.pos) begin
					$error("cursor_position: expected %0d, actual %0d", want.pos, got.pos);
					mismatch_count++;
				end
				if (got.cell_data !== want.cell_data) begin
					$error("cell_data: expected %h, actual %h", want.cell_data, got.cell_data);
					mismatch_count++;
				end
			end
		end
	end

	initial begin : stimulus
		console_report_t fixed_rep;
		logic [CHAR_W-1:0] phase_colour [NUM_PHASES];
		phase_colour = '{8'hFF, 8'h00, CHAR_W'($urandom_range(0, 255)),
			CHAR_W'($urandom_range(0, 255)), 8'h5A};
		colour_reg = RESET_COLOUR;
		blank_screen();
		mark_row = '0;
		mark_col = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_ops[i]) begin
			fixed_rep.pos = directed_ops[i].pos;
			fixed_rep.cell_data = directed_ops[i].cell_data;
			offer_item(directed_ops[i].fn, directed_ops[i].ch, directed_ops[i].r,
				directed_ops[i].c, directed_ops[i].fixed, fixed_rep);
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			settle_console(CELLS + 10);
			load_colour(phase_colour[p]);
			// first phase floods a stalled receiver, third runs with no idling at all
			no_gaps = (p == 0 || p == 2);
			if (p == 0)
				hold_off_req = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++)
				random_console_op();
		end

		settle_console(20);
		if (mismatch_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
